@@ rtl/assert_macros.svh @@
// Assertion helpers used by the top-level RTL file of the converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/cpc_pkg.sv @@
`default_nettype none

package cpc_pkg;

    localparam int OPERAND_W          = 16;
    localparam int RESULT_W           = 17;
    localparam int STAGES_DEFAULT     = 16;
    localparam int DATA_WIDTH_DEFAULT = 16;
    localparam int MAX_STAGES         = 24;
    localparam int ANGLE_SHIFT        = 9;
    localparam int ANGLE_W            = RESULT_W + ANGLE_SHIFT;
    localparam int GUARD_BASE         = 12;
    localparam int GROWTH_W           = 7;

    localparam logic [23:0] GAIN_INV = 24'h9B74EE;

    localparam logic signed [ANGLE_W-1:0] HALF_TURN_Z = ANGLE_W'(180 * 65536);
    localparam logic signed [OPERAND_W:0] HALF_TURN_Q7 = 17'sd23040;
    localparam logic signed [OPERAND_W:0] QUARTER_Q7   = 17'sd11520;

    typedef enum logic {
        OP_TO_POLAR = 1'b0,
        OP_TO_CART  = 1'b1
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  mode;
        logic zero;
    } ctl_t;

    // Arctangent of 2^-i in units of 1/65536 degree.
    function automatic logic [ANGLE_W-1:0] atan_deg(input int unsigned idx);
        logic [ANGLE_W-1:0] v;
        case (idx)
            0:       v = ANGLE_W'(2949120);
            1:       v = ANGLE_W'(1740967);
            2:       v = ANGLE_W'(919879);
            3:       v = ANGLE_W'(466945);
            4:       v = ANGLE_W'(234379);
            5:       v = ANGLE_W'(117304);
            6:       v = ANGLE_W'(58666);
            7:       v = ANGLE_W'(29335);
            8:       v = ANGLE_W'(14668);
            9:       v = ANGLE_W'(7334);
            10:      v = ANGLE_W'(3667);
            11:      v = ANGLE_W'(1833);
            12:      v = ANGLE_W'(917);
            13:      v = ANGLE_W'(458);
            14:      v = ANGLE_W'(229);
            15:      v = ANGLE_W'(115);
            16:      v = ANGLE_W'(57);
            17:      v = ANGLE_W'(29);
            18:      v = ANGLE_W'(14);
            19:      v = ANGLE_W'(7);
            20:      v = ANGLE_W'(4);
            21:      v = ANGLE_W'(2);
            22:      v = ANGLE_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cpc_in_if.sv @@
`default_nettype none

interface cpc_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  opcode;
    logic signed [cpc_pkg::OPERAND_W-1:0] operand_a;
    logic signed [cpc_pkg::OPERAND_W-1:0] operand_b;

    modport source (output valid, output opcode, output operand_a, output operand_b,
                    input ready);
    modport sink (input valid, input opcode, input operand_a, input operand_b,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/cpc_out_if.sv @@
`default_nettype none

interface cpc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cpc_pkg::RESULT_W-1:0] result_a;
    logic signed [cpc_pkg::RESULT_W-1:0] result_b;

    modport source (output valid, output result_a, output result_b, input ready);
    modport sink (input valid, input result_a, input result_b, output ready);
endinterface

`default_nettype wire

@@ rtl/cartesian_polar_converter.sv @@
// Converts one 2-D vector per word between Cartesian and polar form with an
// unrolled CORDIC pipeline: opcode 0 turns (x, y) in Q8.8 into a magnitude in
// Q8.8 and an angle in degrees Q9.7, opcode 1 turns a magnitude and an angle
// in degrees back into (x, y). A new word can be accepted in every cycle that
// the output does not stall. Each result passes one stage that prepares the
// quadrant, one stage per CORDIC iteration, and two stages that remove the
// CORDIC gain with a split multiply and round. The whole pipeline advances
// together, so a result that waits at the output holds every word behind it.
`default_nettype none
`include "assert_macros.svh"

module cartesian_polar_converter #(
    parameter int STAGES     = cpc_pkg::STAGES_DEFAULT,
    parameter int DATA_WIDTH = cpc_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cpc_in_if.sink     req,
    cpc_out_if.source  rsp
);

    localparam int XW = DATA_WIDTH + cpc_pkg::GROWTH_W;
    localparam int AW = cpc_pkg::ANGLE_W;
    localparam int NS = (STAGES < cpc_pkg::MAX_STAGES) ? STAGES : cpc_pkg::MAX_STAGES;

    logic                  en;
    cpc_pkg::ctl_t         ctl_s [NS+1];
    logic signed [XW-1:0]  x_s [NS+1];
    logic signed [XW-1:0]  y_s [NS+1];
    logic signed [AW-1:0]  z_s [NS+1];

    assign en        = !rsp.valid || rsp.ready;
    assign req.ready = en;

    cpc_pre #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req.valid),
        .opcode    (req.opcode),
        .operand_a (req.operand_a),
        .operand_b (req.operand_b),
        .ctl_o     (ctl_s[0]),
        .x_o       (x_s[0]),
        .y_o       (y_s[0]),
        .z_o       (z_s[0])
    );

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        cpc_stage #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX        (i)
        ) u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .ctl_i (ctl_s[i]),
            .x_i   (x_s[i]),
            .y_i   (y_s[i]),
            .z_i   (z_s[i]),
            .ctl_o (ctl_s[i+1]),
            .x_o   (x_s[i+1]),
            .y_o   (y_s[i+1]),
            .z_o   (z_s[i+1])
        );
    end

    cpc_post #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ctl_i    (ctl_s[NS]),
        .x_i      (x_s[NS]),
        .y_i      (y_s[NS]),
        .z_i      (z_s[NS]),
        .valid_o  (rsp.valid),
        .result_a (rsp.result_a),
        .result_b (rsp.result_b)
    );

    `ASSERT_IMPLY(a_stall_blocks_input, clk, rst_n, rsp.valid && !rsp.ready, !req.ready)
    `ASSERT_IMPLY(a_empty_output_admits, clk, rst_n, !rsp.valid, req.ready)
    `ASSERT_NEXT(a_blocked_word_remains, clk, rst_n, !req.ready, rsp.valid)
    `ASSERT_IMPLY(a_new_word_needs_advance, clk, rst_n, $rose(rsp.valid), $past(req.ready))

endmodule

`default_nettype wire

@@ rtl/cpc_pre.sv @@
`default_nettype none

module cpc_pre #(
    parameter int DATA_WIDTH = cpc_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   en,
    input  wire logic                                   in_valid,
    input  wire logic                                   opcode,
    input  wire logic signed [cpc_pkg::OPERAND_W-1:0]  operand_a,
    input  wire logic signed [cpc_pkg::OPERAND_W-1:0]  operand_b,
    output cpc_pkg::ctl_t                               ctl_o,
    output logic signed [DATA_WIDTH+cpc_pkg::GROWTH_W-1:0] x_o,
    output logic signed [DATA_WIDTH+cpc_pkg::GROWTH_W-1:0] y_o,
    output logic signed [cpc_pkg::ANGLE_W-1:0]          z_o
);

    localparam int XW    = DATA_WIDTH + cpc_pkg::GROWTH_W;
    localparam int GUARD = DATA_WIDTH - cpc_pkg::GUARD_BASE;
    localparam int AW    = cpc_pkg::ANGLE_W;
    localparam int NW    = cpc_pkg::OPERAND_W + 1;

    cpc_pkg::ctl_t         ctl_reg, ctl_next;
    logic signed [XW-1:0]  x_reg, x_next;
    logic signed [XW-1:0]  y_reg, y_next;
    logic signed [AW-1:0]  z_reg, z_next;

    logic signed [XW-1:0]  a_sc;
    logic signed [XW-1:0]  b_sc;
    logic signed [NW-1:0]  ang_in;
    logic signed [NW-1:0]  ang_wrap;
    logic signed [NW-1:0]  ang_fold;
    logic                  flip;

    always_comb
    begin
        a_sc   = XW'(operand_a) <<< GUARD;
        b_sc   = XW'(operand_b) <<< GUARD;
        ang_in = NW'(operand_b);

        if (ang_in > cpc_pkg::HALF_TURN_Q7)
        begin
            ang_wrap = ang_in - (cpc_pkg::HALF_TURN_Q7 <<< 1);
        end
        else if (ang_in <= -cpc_pkg::HALF_TURN_Q7)
        begin
            ang_wrap = ang_in + (cpc_pkg::HALF_TURN_Q7 <<< 1);
        end
        else
        begin
            ang_wrap = ang_in;
        end

        // Angles beyond a quarter turn are folded back and the vector is flipped.
        flip = 1'b0;
        if (ang_wrap > cpc_pkg::QUARTER_Q7)
        begin
            ang_fold = ang_wrap - cpc_pkg::HALF_TURN_Q7;
            flip     = 1'b1;
        end
        else if (ang_wrap < -cpc_pkg::QUARTER_Q7)
        begin
            ang_fold = ang_wrap + cpc_pkg::HALF_TURN_Q7;
            flip     = 1'b1;
        end
        else
        begin
            ang_fold = ang_wrap;
        end

        ctl_next.valid = in_valid;
        ctl_next.mode  = cpc_pkg::op_t'(opcode);
        ctl_next.zero  = (opcode == cpc_pkg::OP_TO_POLAR) && (operand_a == '0)
                         && (operand_b == '0);

        if (opcode == cpc_pkg::OP_TO_CART)
        begin
            x_next = flip ? -a_sc : a_sc;
            y_next = '0;
            z_next = AW'(ang_fold) <<< cpc_pkg::ANGLE_SHIFT;
        end
        else if (operand_a[cpc_pkg::OPERAND_W-1])
        begin
            // The left half-plane is mirrored so the iterations see x >= 0.
            x_next = -a_sc;
            y_next = -b_sc;
            z_next = operand_b[cpc_pkg::OPERAND_W-1] ? -cpc_pkg::HALF_TURN_Z
                                                      : cpc_pkg::HALF_TURN_Z;
        end
        else
        begin
            x_next = a_sc;
            y_next = b_sc;
            z_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign ctl_o = ctl_reg;
    assign x_o   = x_reg;
    assign y_o   = y_reg;
    assign z_o   = z_reg;

endmodule

`default_nettype wire

@@ rtl/cpc_stage.sv @@
`default_nettype none

module cpc_stage #(
    parameter int DATA_WIDTH = cpc_pkg::DATA_WIDTH_DEFAULT,
    parameter int IDX        = 0
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      en,
    input  wire cpc_pkg::ctl_t                             ctl_i,
    input  wire logic signed [DATA_WIDTH+cpc_pkg::GROWTH_W-1:0] x_i,
    input  wire logic signed [DATA_WIDTH+cpc_pkg::GROWTH_W-1:0] y_i,
    input  wire logic signed [cpc_pkg::ANGLE_W-1:0]        z_i,
    output cpc_pkg::ctl_t                                  ctl_o,
    output logic signed [DATA_WIDTH+cpc_pkg::GROWTH_W-1:0] x_o,
    output logic signed [DATA_WIDTH+cpc_pkg::GROWTH_W-1:0] y_o,
    output logic signed [cpc_pkg::ANGLE_W-1:0]             z_o
);

    localparam int XW = DATA_WIDTH + cpc_pkg::GROWTH_W;
    localparam int AW = cpc_pkg::ANGLE_W;
    localparam logic signed [AW-1:0] ATAN = $signed(cpc_pkg::atan_deg(IDX));

    cpc_pkg::ctl_t         ctl_reg;
    logic signed [XW-1:0]  x_reg, x_next;
    logic signed [XW-1:0]  y_reg, y_next;
    logic signed [AW-1:0]  z_reg, z_next;
    logic signed [XW-1:0]  x_sh;
    logic signed [XW-1:0]  y_sh;
    logic                  cw;

    always_comb
    begin
        x_sh = x_i >>> IDX;
        y_sh = y_i >>> IDX;
        // Vectoring drives y toward zero, rotation drives the angle toward zero.
        if (ctl_i.mode == cpc_pkg::OP_TO_CART)
        begin
            cw = z_i[AW-1];
        end
        else
        begin
            cw = !y_i[XW-1] && (y_i != '0);
        end

        if (cw)
        begin
            x_next = x_i + y_sh;
            y_next = y_i - x_sh;
            z_next = z_i + ATAN;
        end
        else
        begin
            x_next = x_i - y_sh;
            y_next = y_i + x_sh;
            z_next = z_i - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign ctl_o = ctl_reg;
    assign x_o   = x_reg;
    assign y_o   = y_reg;
    assign z_o   = z_reg;

endmodule

`default_nettype wire

@@ rtl/cpc_post.sv @@
`default_nettype none

module cpc_post #(
    parameter int DATA_WIDTH = cpc_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      en,
    input  wire cpc_pkg::ctl_t                             ctl_i,
    input  wire logic signed [DATA_WIDTH+cpc_pkg::GROWTH_W-1:0] x_i,
    input  wire logic signed [DATA_WIDTH+cpc_pkg::GROWTH_W-1:0] y_i,
    input  wire logic signed [cpc_pkg::ANGLE_W-1:0]        z_i,
    output logic                                           valid_o,
    output logic signed [cpc_pkg::RESULT_W-1:0]            result_a,
    output logic signed [cpc_pkg::RESULT_W-1:0]            result_b
);

    localparam int XW    = DATA_WIDTH + cpc_pkg::GROWTH_W;
    localparam int GUARD = DATA_WIDTH - cpc_pkg::GUARD_BASE;
    localparam int AW    = cpc_pkg::ANGLE_W;
    localparam int RW    = cpc_pkg::RESULT_W;
    localparam int LW    = XW / 2;
    localparam int HW    = XW - LW;
    localparam int PLW   = LW + 24;
    localparam int PHW   = HW + 25;
    localparam int FW    = XW + 25;
    localparam int SH    = 24 + GUARD;

    localparam logic [PLW-1:0]        GAIN_L = PLW'(cpc_pkg::GAIN_INV);
    localparam logic signed [PHW-1:0] GAIN_H = PHW'({1'b0, cpc_pkg::GAIN_INV});
    localparam logic [FW-1:0]         RND    = FW'(1) << (SH - 1);
    localparam logic signed [AW-1:0]  Z_RND  = AW'(1) <<< (cpc_pkg::ANGLE_SHIFT - 1);

    cpc_pkg::ctl_t          ctl1_reg;
    logic [PLW-1:0]         pxl_reg, pxl_next;
    logic [PLW-1:0]         pyl_reg, pyl_next;
    logic signed [PHW-1:0]  pxh_reg, pxh_next;
    logic signed [PHW-1:0]  pyh_reg, pyh_next;
    logic [RW-1:0]          zr_reg, zr_next;
    logic signed [HW-1:0]   xh;
    logic signed [HW-1:0]   yh;
    logic signed [AW-1:0]   zsum;

    logic                   valid_reg;
    logic [RW-1:0]          ra_reg, ra_next;
    logic [RW-1:0]          rb_reg, rb_next;
    logic [FW-1:0]          fx;
    logic [FW-1:0]          fy;

    // The gain correction is split into low and high partial products.
    always_comb
    begin
        xh       = x_i[XW-1:LW];
        yh       = y_i[XW-1:LW];
        pxl_next = PLW'(x_i[LW-1:0]) * GAIN_L;
        pyl_next = PLW'(y_i[LW-1:0]) * GAIN_L;
        pxh_next = PHW'(xh) * GAIN_H;
        pyh_next = PHW'(yh) * GAIN_H;
        zsum     = z_i + Z_RND;
        zr_next  = zsum[AW-1:cpc_pkg::ANGLE_SHIFT];
    end

    always_comb
    begin
        fx = (FW'(pxh_reg) << LW) + FW'(pxl_reg) + RND;
        fy = (FW'(pyh_reg) << LW) + FW'(pyl_reg) + RND;
        if (ctl1_reg.mode == cpc_pkg::OP_TO_CART)
        begin
            ra_next = fx[SH+RW-1:SH];
            rb_next = fy[SH+RW-1:SH];
        end
        else if (ctl1_reg.zero)
        begin
            ra_next = '0;
            rb_next = '0;
        end
        else
        begin
            ra_next = fx[SH+RW-1:SH];
            rb_next = zr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ctl1_reg  <= ctl_i;
            valid_reg <= ctl1_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxl_reg <= pxl_next;
            pyl_reg <= pyl_next;
            pxh_reg <= pxh_next;
            pyh_reg <= pyh_next;
            zr_reg  <= zr_next;
            ra_reg  <= ra_next;
            rb_reg  <= rb_next;
        end
    end

    assign valid_o  = valid_reg;
    assign result_a = $signed(ra_reg);
    assign result_b = $signed(rb_reg);

endmodule

`default_nettype wire

@@ test/cpc_checker.sv @@
`default_nettype none

module cpc_checker #(
    parameter int STAGES     = cpc_pkg::STAGES_DEFAULT,
    parameter int DATA_WIDTH = cpc_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cpc_in_if         req,
    cpc_out_if        rsp,
    output int        fault_count,
    output int        words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import cpc_pkg::*;

    typedef struct packed {
        logic signed [RESULT_W-1:0] result_a;
        logic signed [RESULT_W-1:0] result_b;
    } vector_t;

    localparam int     GUARD     = DATA_WIDTH - 12;
    localparam int     ARC_COUNT = 24;
    localparam longint GAIN_Q24  = 64'd10188014;
    localparam longint HALF_Z    = 64'd180 * 64'd65536;
    localparam longint HALF_Q7   = 64'd180 * 64'd128;

    // Arctangent of 2^-i, in 1/65536 degree.
    localparam longint ARC_DEG [0:ARC_COUNT-1] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    vector_t conversions_due[$];
    int      faults = 0;
    int      due    = 0;

    assign fault_count = faults;
    assign words_due   = due;

    function automatic longint round_shift(input longint v, input int s);
        if (s == 0)
            return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint remove_gain(input longint v);
        return round_shift(v * GAIN_Q24, 24 + GUARD);
    endfunction

    function automatic vector_t convert_vector(input op_t op,
                                               input logic signed [OPERAND_W-1:0] a,
                                               input logic signed [OPERAND_W-1:0] b);
        vector_t res;
        longint  x;
        longint  y;
        longint  z;
        longint  t;
        longint  ang;
        longint  ra;
        longint  rb;
        if (op == OP_TO_POLAR)
        begin
            x = longint'(a) * (longint'(1) << GUARD);
            y = longint'(b) * (longint'(1) << GUARD);
            z = 0;
            if (x < 0)
            begin
                z = (y >= 0) ? HALF_Z : -HALF_Z;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < STAGES && i < ARC_COUNT; i++)
            begin
                if (y > 0)
                begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    z = z + ARC_DEG[i];
                end
                else
                begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    z = z - ARC_DEG[i];
                end
                x = t;
            end
            if (a == 0 && b == 0)
            begin
                ra = 0;
                rb = 0;
            end
            else
            begin
                ra = remove_gain(x);
                rb = round_shift(z, 9);
            end
        end
        else
        begin
            ang = longint'(b);
            if (ang > HALF_Q7)
                ang = ang - 2 * HALF_Q7;
            else if (ang <= -HALF_Q7)
                ang = ang + 2 * HALF_Q7;
            x = longint'(a) * (longint'(1) << GUARD);
            if (ang > HALF_Q7 / 2)
            begin
                ang = ang - HALF_Q7;
                x = -x;
            end
            else if (ang < -HALF_Q7 / 2)
            begin
                ang = ang + HALF_Q7;
                x = -x;
            end
            y = 0;
            z = ang * 512;
            for (int i = 0; i < STAGES && i < ARC_COUNT; i++)
            begin
                if (z >= 0)
                begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    z = z - ARC_DEG[i];
                end
                else
                begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    z = z + ARC_DEG[i];
                end
                x = t;
            end
            ra = remove_gain(x);
            rb = remove_gain(y);
        end
        res.result_a = ra[RESULT_W-1:0];
        res.result_b = rb[RESULT_W-1:0];
        return res;
    endfunction

    always @(posedge clk)
    begin
        vector_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
                conversions_due.push_back(convert_vector(op_t'(req.opcode),
                                                         req.operand_a, req.operand_b));
            if (rsp.valid && rsp.ready)
            begin
                if (conversions_due.size() == 0)
                begin
                    $error("result word with nothing due: result_a %0d, result_b %0d",
                           rsp.result_a, rsp.result_b);
                    faults++;
                end
                else
                begin
                    want = conversions_due.pop_front();
                    if (rsp.result_a !== want.result_a)
                    begin
                        $error("result_a: expected %0d, got %0d", want.result_a, rsp.result_a);
                        faults++;
                    end
                    if (rsp.result_b !== want.result_b)
                    begin
                        $error("result_b: expected %0d, got %0d", want.result_b, rsp.result_b);
                        faults++;
                    end
                end
            end
            due = conversions_due.size();
        end
    end
endmodule

`default_nettype wire

@@ test/cartesian_polar_converter_tb.sv @@
`default_nettype none

module cartesian_polar_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpc_pkg::*;

    localparam int STAGES     = STAGES_DEFAULT;
    localparam int DATA_WIDTH = DATA_WIDTH_DEFAULT;
    localparam int LATENCY    = STAGES + 3;
    localparam int IDLE_LIMIT = 2000;

    logic clk;
    logic rst_n;
    int   fault_count;
    int   words_due;
    bit   source_gaps;
    bit   sink_gaps;
    bit   hold_request;

    cpc_in_if  req_if ();
    cpc_out_if rsp_if ();

    cartesian_polar_converter #(
        .STAGES     (STAGES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    cpc_checker #(
        .STAGES     (STAGES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_if),
        .rsp         (rsp_if),
        .fault_count (fault_count),
        .words_due   (words_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic send_word(input op_t op, input logic [OPERAND_W-1:0] a,
                             input logic [OPERAND_W-1:0] b);
        int gap;
        if (source_gaps && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 5);
            repeat (gap)
            begin
                @(negedge clk);
                req_if.valid <= 1'b0;
            end
        end
        @(negedge clk);
        req_if.valid     <= 1'b1;
        req_if.opcode    <= op;
        req_if.operand_a <= a;
        req_if.operand_b <= b;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    task automatic send_random();
        op_t             op;
        logic [OPERAND_W-1:0] a;
        logic [OPERAND_W-1:0] b;
        int              angle;
        op = op_t'($urandom_range(0, 1));
        a  = OPERAND_W'($urandom);
        b  = OPERAND_W'($urandom);
        case ($urandom_range(0, 3))
            0:
            begin
                a = {{6{a[9]}}, a[9:0]};
                b = {{6{b[9]}}, b[9:0]};
            end
            1, 2:
            begin
                if (op == OP_TO_CART)
                begin
                    angle = $urandom_range(0, 46080);
                    b = 16'(angle - 23040);
                end
            end
            default: ;
        endcase
        send_word(op, a, b);
    endtask

    task automatic drain();
        @(negedge clk);
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int hold;
        bit held_once;
        hold      = 0;
        held_once = 1'b0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !held_once)
            begin
                held_once = 1'b1;
                hold = 150;
            end
            if (hold > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold--;
            end
            else if (sink_gaps && $urandom_range(0, 6) == 0)
            begin
                hold = $urandom_range(0, 4);
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        req_if.valid     = 1'b0;
        req_if.opcode    = OP_TO_POLAR;
        req_if.operand_a = '0;
        req_if.operand_b = '0;
        source_gaps      = 1'b1;
        sink_gaps        = 1'b1;
        hold_request     = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_word(OP_TO_POLAR, 16'sd0, 16'sd0);
        send_word(OP_TO_POLAR, 16'sd256, 16'sd0);
        send_word(OP_TO_POLAR, -16'sd256, 16'sd0);
        send_word(OP_TO_POLAR, -16'sd256, -16'sd256);
        send_word(OP_TO_POLAR, 16'sd0, 16'sd256);
        send_word(OP_TO_POLAR, 16'sd0, -16'sd256);
        send_word(OP_TO_POLAR, 16'sd32767, 16'sd32767);
        send_word(OP_TO_POLAR, -16'sd32768, -16'sd32768);
        send_word(OP_TO_POLAR, -16'sd32768, 16'sd0);
        send_word(OP_TO_POLAR, 16'sd32767, -16'sd32768);
        send_word(OP_TO_POLAR, -16'sd1, 16'sd1);
        send_word(OP_TO_CART, 16'sd256, 16'sd0);
        send_word(OP_TO_CART, 16'sd256, 16'sd23040);
        send_word(OP_TO_CART, 16'sd256, -16'sd23040);
        send_word(OP_TO_CART, 16'sd256, 16'sd23041);
        send_word(OP_TO_CART, 16'sd256, 16'sd11520);
        send_word(OP_TO_CART, 16'sd256, 16'sd11521);
        send_word(OP_TO_CART, 16'sd256, -16'sd11521);
        send_word(OP_TO_CART, -16'sd256, 16'sd5760);
        send_word(OP_TO_CART, 16'sd32767, 16'sd32767);
        send_word(OP_TO_CART, -16'sd32768, -16'sd32768);
        send_word(OP_TO_CART, 16'sd32767, -16'sd11520);
        send_word(OP_TO_CART, 16'sd0, 16'sd1234);
        drain();

        repeat (300) send_random();

        // Stall the output for a long stretch while words keep coming, so the
        // pipeline fills and back-pressures the input.
        source_gaps  = 1'b0;
        hold_request = 1'b1;
        repeat (60) send_random();
        source_gaps = 1'b1;
        drain();

        repeat (300) send_random();

        source_gaps = 1'b0;
        sink_gaps   = 1'b0;
        repeat (90) send_random();
        drain();

        repeat (LATENCY + 8) @(posedge clk);
        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/cpc_pkg.sv
rtl/cpc_in_if.sv
rtl/cpc_out_if.sv
rtl/cpc_pre.sv
rtl/cpc_stage.sv
rtl/cpc_post.sv
rtl/cartesian_polar_converter.sv
test/cpc_checker.sv
test/cartesian_polar_converter_tb.sv
